>>> sv/sliding_window_mean_stddev_defines.svh
// ----------------------------------------------------------------------------
// Sliding window mean and deviation: assertion macros
// Shared concurrent assertion forms on clk with active-low reset rst_n.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEAN_STDDEV_DEFINES_SVH
`define SLIDING_WINDOW_MEAN_STDDEV_DEFINES_SVH

// Same-cycle implication
`define SWMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SWMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/swms_pkg.sv
// ----------------------------------------------------------------------------
// swms_pkg
// Field widths, parameter defaults and sequencer states shared by the
// sliding window mean and standard deviation block.
// ----------------------------------------------------------------------------
package swms_pkg;

    // Item field widths
    localparam int LAP_W  = 20;
    localparam int MEAN_W = 24;
    localparam int SD_W   = 24;
    localparam int HELD_W = 4;

    // Parameter defaults
    localparam int WINDOW_DEF        = 10;
    localparam int SAMPLE_BITS_DEF   = 20;
    localparam int FRACTION_BITS_DEF = 4;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ_OLD,
        ST_UPDATE,
        ST_ADD_SQ,
        ST_SCALE,
        ST_MEAN_DIV,
        ST_VAR_DIV,
        ST_ROOT,
        ST_DONE
    } swms_state_t;

endpackage

>>> sv/swms_lap_if.sv
// ----------------------------------------------------------------------------
// swms_lap_if
// Input channel: one lap duration per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface swms_lap_if;
    import swms_pkg::*;

    logic             valid;
    logic             ready;
    logic [LAP_W-1:0] lap_ms;

    modport source (output valid, output lap_ms, input ready);
    modport sink   (input valid, input lap_ms, output ready);
endinterface

>>> sv/swms_stat_if.sv
// ----------------------------------------------------------------------------
// swms_stat_if
// Result channel: latest duration, window mean, deviation and fill count.
// ----------------------------------------------------------------------------
interface swms_stat_if;
    import swms_pkg::*;

    logic              valid;
    logic              ready;
    logic [LAP_W-1:0]  latest_ms;
    logic [MEAN_W-1:0] mean_x16;
    logic [SD_W-1:0]   stddev_x16;
    logic [HELD_W-1:0] samples_held;

    modport source (output valid, output latest_ms, output mean_x16,
                    output stddev_x16, output samples_held, input ready);
    modport sink   (input valid, input latest_ms, input mean_x16,
                    input stddev_x16, input samples_held, output ready);
endinterface

>>> sv/sliding_window_mean_stddev.sv
// ----------------------------------------------------------------------------
// sliding_window_mean_stddev
// Each accepted item passes through four update states (READ, SQ_OLD,
// UPDATE, ADD_SQ), CNT_W shift-add steps, then SUM_W+FRACTION_BITS and SC_W
// restoring divide steps and SC_W/2 root steps, one bit a cycle; the variance
// divide and root steps run only once two or more samples are held. The next
// item is taken once the result is loaded and while it waits at the output.
// Reset clears the sums, fill count, write slot and output valid at once.
// ----------------------------------------------------------------------------
module sliding_window_mean_stddev #(
    parameter int WINDOW        = swms_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS   = swms_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = swms_pkg::FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    swms_lap_if.sink     laps,
    swms_stat_if.source  stats
);
    import swms_pkg::*;

    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W;
    localparam int PROD_W = 2 * SUM_W;
    localparam int A_W    = SQ_W + CNT_W;
    localparam int SC_W   = A_W + 2 * FRACTION_BITS;
    localparam int MD_W   = SUM_W + FRACTION_BITS;
    localparam int DV_W   = 2 * CNT_W;
    localparam int RT_W   = SC_W / 2;
    localparam int ITER_W = $clog2(SC_W);
    localparam int EXT_W  = (SAMPLE_BITS > LAP_W) ? SAMPLE_BITS : LAP_W;

    // Control state
    swms_state_t        state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SQ_W-1:0]    sumsq_reg;
    logic               out_valid_reg;

    // Datapath registers
    logic [SAMPLE_BITS-1:0] lap_reg;
    logic [SAMPLE_BITS-1:0] old_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [A_W-1:0]         acc_reg;
    logic [SC_W-1:0]        quo_reg;
    logic [DV_W-1:0]        rem_reg;
    logic [DV_W-1:0]        dvar_reg;
    logic [RT_W-1:0]        root_reg;
    logic [RT_W:0]          srem_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic [MEAN_W-1:0]      mean_reg;
    logic [LAP_W-1:0]       out_latest_reg;
    logic [MEAN_W-1:0]      out_mean_reg;
    logic [SD_W-1:0]        out_sd_reg;
    logic [HELD_W-1:0]      out_held_reg;

    logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];

    // Handshake decode
    logic in_ready;
    logic in_accept;
    logic out_load;

    // Shared datapath signals
    logic               full;
    logic               two_plus;
    logic               last_iter;
    logic [EXT_W-1:0]   lap_ext;
    logic [EXT_W-1:0]   lap_max;
    logic [SAMPLE_BITS-1:0] lap_sat;
    logic [SUM_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]  mul_p;
    logic [CNT_W-1:0]   cnt_shr;
    logic [A_W-1:0]     num;
    logic [DV_W-1:0]    divisor;
    logic [DV_W:0]      rem_sh;
    logic [DV_W:0]      rem_diff;
    logic               qbit;
    logic [DV_W-1:0]    rem_next;
    logic [SC_W-1:0]    quo_next;
    logic [RT_W+2:0]    srem_sh;
    logic [RT_W+2:0]    trial;
    logic [RT_W+2:0]    srem_diff;

    assign full      = (cnt_reg == CNT_W'(WINDOW));
    assign two_plus  = (cnt_reg >= CNT_W'(2));
    assign last_iter = (iter_reg == '0);

    // Saturate the incoming duration to the sample range
    assign lap_ext = EXT_W'(laps.lap_ms);
    assign lap_max = EXT_W'({SAMPLE_BITS{1'b1}});
    assign lap_sat = (lap_ext > lap_max) ? SAMPLE_BITS'(lap_max) : SAMPLE_BITS'(lap_ext);

    // Shared multiplier operand selection
    always_comb
    begin
        case (state_reg)
            ST_SQ_OLD:
            begin
                mul_a = SUM_W'(old_reg);
                mul_b = SUM_W'(old_reg);
            end
            ST_UPDATE:
            begin
                mul_a = SUM_W'(lap_reg);
                mul_b = SUM_W'(lap_reg);
            end
            default:
            begin
                mul_a = sum_reg;
                mul_b = sum_reg;
            end
        endcase
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Count bit for the shift-add of count times sum of squares
    assign cnt_shr = cnt_reg >> iter_reg;

    // Numerator count*sumsq - sum^2, clamped at zero
    assign num = (acc_reg > A_W'(prod_reg)) ? acc_reg - A_W'(prod_reg) : '0;

    // Restoring divide step, one quotient bit a cycle
    assign divisor  = (state_reg == ST_VAR_DIV) ? dvar_reg : DV_W'(cnt_reg);
    assign rem_sh   = {rem_reg, quo_reg[SC_W-1]};
    assign rem_diff = rem_sh - (DV_W+1)'(divisor);
    assign qbit     = (rem_sh >= (DV_W+1)'(divisor));
    assign rem_next = qbit ? rem_diff[DV_W-1:0] : rem_sh[DV_W-1:0];
    assign quo_next = {quo_reg[SC_W-2:0], qbit};

    // Square root step, one root bit a cycle
    assign srem_sh   = {srem_reg, quo_reg[SC_W-1 -: 2]};
    assign trial     = (RT_W+3)'({root_reg, 2'b01});
    assign srem_diff = srem_sh - trial;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (laps.valid) state_next = ST_READ;
            ST_READ:     state_next = ST_SQ_OLD;
            ST_SQ_OLD:   state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_ADD_SQ;
            ST_ADD_SQ:   state_next = ST_SCALE;
            ST_SCALE:    if (last_iter) state_next = ST_MEAN_DIV;
            ST_MEAN_DIV:
            begin
                if (last_iter)
                begin
                    state_next = two_plus ? ST_VAR_DIV : ST_DONE;
                end
            end
            ST_VAR_DIV:  if (last_iter) state_next = ST_ROOT;
            ST_ROOT:     if (last_iter) state_next = ST_DONE;
            ST_DONE:     if (out_load) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_DONE) && (!out_valid_reg || stats.ready);
    end

    assign in_accept = laps.valid && in_ready;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            sumsq_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Drop the oldest sample once full, add the new one
            if (state_reg == ST_UPDATE)
            begin
                sum_reg   <= sum_reg - (full ? SUM_W'(old_reg) : '0) + SUM_W'(lap_reg);
                sumsq_reg <= sumsq_reg - (full ? SQ_W'(prod_reg) : '0);
                if (!full)
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
                slot_reg <= (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end

            if (state_reg == ST_ADD_SQ)
            begin
                sumsq_reg <= sumsq_reg + SQ_W'(prod_reg);
            end

            // Hold the result until taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stats.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Sample ring: read the outgoing entry, write the new one
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            old_reg            <= ring_mem[slot_reg];
            ring_mem[slot_reg] <= lap_reg;
        end
    end

    // Datapath sequencing
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            lap_reg <= lap_sat;
        end

        case (state_reg)
            ST_SQ_OLD, ST_UPDATE:
            begin
                prod_reg <= mul_p;
            end
            ST_ADD_SQ:
            begin
                prod_reg <= mul_p;
                dvar_reg <= DV_W'(cnt_reg) * DV_W'(cnt_reg - 1'b1);
                acc_reg  <= '0;
                iter_reg <= ITER_W'(CNT_W - 1);
            end
            ST_SCALE:
            begin
                acc_reg <= (acc_reg << 1) + (cnt_shr[0] ? A_W'(sumsq_reg) : '0);
                if (last_iter)
                begin
                    quo_reg  <= SC_W'(sum_reg) << (SC_W - SUM_W);
                    rem_reg  <= '0;
                    iter_reg <= ITER_W'(MD_W - 1);
                end
                else
                begin
                    iter_reg <= iter_reg - 1'b1;
                end
            end
            ST_MEAN_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (last_iter)
                begin
                    mean_reg <= MEAN_W'(quo_next);
                    quo_reg  <= SC_W'(num) << (2 * FRACTION_BITS);
                    rem_reg  <= '0;
                    iter_reg <= ITER_W'(SC_W - 1);
                end
                else
                begin
                    iter_reg <= iter_reg - 1'b1;
                end
            end
            ST_VAR_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                if (last_iter)
                begin
                    root_reg <= '0;
                    srem_reg <= '0;
                    iter_reg <= ITER_W'(RT_W - 1);
                end
                else
                begin
                    iter_reg <= iter_reg - 1'b1;
                end
            end
            ST_ROOT:
            begin
                quo_reg <= quo_reg << 2;
                if (srem_sh >= trial)
                begin
                    srem_reg <= srem_diff[RT_W:0];
                    root_reg <= {root_reg[RT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= srem_sh[RT_W:0];
                    root_reg <= {root_reg[RT_W-2:0], 1'b0};
                end
                iter_reg <= iter_reg - 1'b1;
            end
            default:
            begin
            end
        endcase

        // Load the output stage
        if (out_load)
        begin
            out_latest_reg <= LAP_W'(lap_reg);
            out_mean_reg   <= mean_reg;
            out_sd_reg     <= two_plus ? SD_W'(root_reg) : '0;
            out_held_reg   <= HELD_W'(cnt_reg);
        end
    end

    assign laps.ready         = in_ready;
    assign stats.valid        = out_valid_reg;
    assign stats.latest_ms    = out_latest_reg;
    assign stats.mean_x16     = out_mean_reg;
    assign stats.stddev_x16   = out_sd_reg;
    assign stats.samples_held = out_held_reg;

endmodule

>>> sv/swms_checker.sv
// ----------------------------------------------------------------------------
// swms_checker
// Port-level checks on the sliding window block, attached by bind.
// ----------------------------------------------------------------------------
`include "sliding_window_mean_stddev_defines.svh"

module swms_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [swms_pkg::LAP_W-1:0]  latest_ms,
    input logic [swms_pkg::MEAN_W-1:0] mean_x16,
    input logic [swms_pkg::SD_W-1:0]   stddev_x16,
    input logic [swms_pkg::HELD_W-1:0] samples_held
);
    import swms_pkg::*;

    logic in_accept;
    logic out_stall;
    logic [LAP_W+MEAN_W+SD_W+HELD_W-1:0] out_bus;

    assign in_accept = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;
    assign out_bus   = {latest_ms, mean_x16, stddev_x16, samples_held};

    // A stalled result holds with all of its fields
    `SWMS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(out_bus), "stall not held")

    // Busy once an item is taken
    `SWMS_ASSERT_NEXT(a_busy_after_accept, in_accept, !in_ready, "ready after accept")

    // A result never appears straight after an item is taken
    `SWMS_ASSERT_NOW(a_no_instant_result, $rose(out_valid), !$past(in_accept), "result too early")

endmodule

bind sliding_window_mean_stddev swms_checker u_swms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (laps.valid),
    .in_ready     (laps.ready),
    .out_valid    (stats.valid),
    .out_ready    (stats.ready),
    .latest_ms    (stats.latest_ms),
    .mean_x16     (stats.mean_x16),
    .stddev_x16   (stats.stddev_x16),
    .samples_held (stats.samples_held)
);
